// ===== design/acrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acrm_pkg
// Constants and helpers for the arccos rational minimax unit.
// ---------------------------------------------------------------------------
package acrm_pkg;
    localparam int W_BITS = 30;
    localparam logic signed [35:0] ONE_W = 36'sd1073741824;
    localparam logic signed [35:0] R_LIMIT = 36'sd8589934592;
    localparam logic signed [35:0] PIO2_W = 36'sd1686629713;
    localparam logic signed [35:0] PI_W = 36'sd3373259426;

    localparam logic signed [35:0] NUM_C [6] = '{
        36'sd178956971, -36'sd349573636, 36'sd216050311,
        -36'sd43009303, 36'sd849904, 36'sd37359};
    localparam logic signed [35:0] DEN_C [5] = '{
        36'sd1073741824, -36'sd2580625636, 36'sd2169973987,
        -36'sd739039287, 36'sd82719084};

    localparam int DIV_STEPS = 35;

    // Q.30 signed product, round half away from zero.
    function automatic logic signed [35:0] qmul(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic [35:0] ma;
        logic [35:0] mb;
        logic [71:0] pr;
        logic [41:0] m;
        ma = a[35] ? 36'(-a) : 36'(a);
        mb = b[35] ? 36'(-b) : 36'(b);
        pr = ma * mb;
        m = 42'((pr + (72'd1 << (W_BITS - 1))) >> W_BITS);
        return (a[35] ^ b[35]) ? -$signed(36'(m)) : $signed(36'(m));
    endfunction
endpackage
`default_nettype wire

// ===== design/arccos_rational_minimax_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// arccos_rational_minimax_unit
// Pipelined acos(x) in Q2.30 by a rational minimax fit near zero.
// ---------------------------------------------------------------------------
// Usage:
//   Pulse i_start with i_x_value; o_busy is always low, so one transfer can
//   be made each cycle. o_done strobes for one cycle with o_angle.
// Pipeline: NS = 12 + DIV_STEPS register stages: clamp, square, five Horner
//   stages for p (four for q in parallel, then a floor on q), z*p, a restoring
//   divider of one quotient bit per stage, sign/limit of r, x*r, subtract,
//   output saturate. o_done is the last stage's valid bit and rises with
//   o_angle from that stage's register.
// Throughput is one item per cycle; each stage holds one item and its
//   valid bit.
// Reset: clears all valid bits; no result strobes until new transfers.
// The receiver cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
module arccos_rational_minimax_unit
    import acrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_x_value,
    output logic             o_done,
    output logic [31:0]      o_angle
);
    localparam int NS = 12 + DIV_STEPS;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] z;
        logic signed [35:0] p;
        logic signed [35:0] q;
        logic [71:0]        rem;   // divider remainder / numerator bits
        logic [35:0]        quo;
        logic               neg;
    } t_stage;

    logic   r_v [NS];
    t_stage r_s [NS];
    t_stage n_s [NS];

    assign o_busy = 1'b0;

    always_comb begin
        logic [31:0] xm;
        logic [72:0] trial;
        logic [71:0] num;
        logic [35:0] rm;
        n_s[0] = '0;
        for (int k = 1; k < NS; k++) n_s[k] = r_s[k-1];
        // stage 0: magnitude clamp
        xm = i_x_value[31] ? 32'(-i_x_value) : i_x_value;
        if (xm > 32'(ONE_W)) xm = 32'(ONE_W);
        n_s[0].x = i_x_value[31] ? -$signed({4'd0, xm}) : $signed({4'd0, xm});
        // stage 1: square, seed p, q
        n_s[1].z = qmul(r_s[0].x, r_s[0].x);
        n_s[1].p = NUM_C[5];
        n_s[1].q = DEN_C[4];
        // stages 2..5: Horner steps for p and q
        for (int k = 2; k <= 5; k++) begin
            n_s[k].p = NUM_C[6-k] + qmul(r_s[k-1].z, r_s[k-1].p);
            n_s[k].q = DEN_C[5-k] + qmul(r_s[k-1].z, r_s[k-1].q);
        end
        // stage 6: last p step, q floor
        n_s[6].p = NUM_C[0] + qmul(r_s[5].z, r_s[5].p);
        if (r_s[5].q < 36'sd1) n_s[6].q = 36'sd1;
        // stage 7: z*p, build rounded numerator
        n_s[7].p = qmul(r_s[6].z, r_s[6].p);
        n_s[7].neg = n_s[7].p[35];
        num = {36'd0, (n_s[7].p[35] ? 36'(-n_s[7].p) : 36'(n_s[7].p))};
        n_s[7].rem = 72'((num << W_BITS) + 72'(r_s[6].q >>> 1));
        n_s[7].quo = '0;
        // restoring division, one bit per stage, MSB first
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {1'b0, r_s[7+k].rem} -
                    ({37'd0, r_s[7+k].q} << (DIV_STEPS - 1 - k));
            n_s[8+k].quo = {r_s[7+k].quo[34:0], ~trial[72]};
            if (!trial[72]) n_s[8+k].rem = trial[71:0];
        end
        // saturate and sign r
        rm = r_s[7+DIV_STEPS].quo;
        if (rm > 36'(R_LIMIT)) rm = 36'(R_LIMIT);
        n_s[8+DIV_STEPS].p = r_s[7+DIV_STEPS].neg ? -$signed(rm) : $signed(rm);
        // x*r
        n_s[9+DIV_STEPS].p = qmul(r_s[8+DIV_STEPS].x, r_s[8+DIV_STEPS].p);
        // y
        n_s[10+DIV_STEPS].p = PIO2_W - (r_s[9+DIV_STEPS].x + r_s[9+DIV_STEPS].p);
        n_s[11+DIV_STEPS].p = r_s[10+DIV_STEPS].p;
        if (r_s[10+DIV_STEPS].p < 0) n_s[11+DIV_STEPS].p = '0;
        if (r_s[10+DIV_STEPS].p > PI_W) n_s[11+DIV_STEPS].p = PI_W;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) r_s[k] <= n_s[k];
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_start;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    assign o_done  = r_v[NS-1];
    assign o_angle = r_s[NS-1].p[31:0];

`ifndef NO_ASSERTIONS
    a_no_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy asserted");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##(NS-1) o_done)
        else $error("result lost");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle <= 32'(PI_W)))
        else $error("angle out of range");
`endif
endmodule
`default_nettype wire
